// ===== rtl/core/tilt_pid_balance_controller_core_assert.svh =====
// Assertion macros shared by the tilt PID balance controller RTL.
`ifndef TILT_PID_BALANCE_CONTROLLER_CORE_ASSERT_SVH
`define TILT_PID_BALANCE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TPBC_ASSERT_IMP(lbl, clk_i, rst_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TPBC_ASSERT_NXT(lbl, clk_i, rst_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tpbc_pkg.sv =====
// Package with widths, constants and register codes of the tilt PID balance controller.
`default_nettype none

package tpbc_pkg;

    // Parameter defaults
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 10;

    // Field and datapath widths
    localparam int GAIN_W    = 16;
    localparam int TILT_W    = 17;
    localparam int OFF_W     = 10;
    localparam int LIM_W     = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int ERR_W     = 18;
    localparam int ACC_W     = 22;
    localparam int DER_W     = 19;
    localparam int DRIVE_W   = 9;
    localparam int WHEEL_W   = 8;
    localparam int ANGLE_W   = 26;
    localparam int FRAC_BITS = 16;
    localparam int PP_W      = GAIN_W + ERR_W;
    localparam int PI_W      = GAIN_W + ACC_W;
    localparam int PD_W      = GAIN_W + DER_W;
    localparam int SUM_W     = 40;

    // Register reset values
    localparam int GAIN_P_RST = 77;
    localparam int GAIN_I_RST = 0;
    localparam int GAIN_D_RST = 64;
    localparam int TARGET_RST = 0;
    localparam int OFF_Y_RST  = 0;
    localparam int OFF_Z_RST  = 0;
    localparam int LIMIT_RST  = 5120;

    // Angle arithmetic, 1/65536 degree inside the CORDIC
    localparam int ATAN_LEN    = 24;
    localparam int ATAN_TAB [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam int Z_QUARTER   = 90 * 65536;
    localparam int ROUND_HALF  = 128;
    localparam int ROUND_SHIFT = 8;
    localparam int ANGLE_MAX   = 46080;

    // Drive and servo limits
    localparam int DRIVE_SHIFT = 8;
    localparam int DRIVE_MAX   = 255;
    localparam int SERVO_SPAN  = 90;
    localparam int WHEEL_SUM   = 180;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_GAIN_P   = 3'd0;
    localparam cfg_idx_t REG_GAIN_I   = 3'd1;
    localparam cfg_idx_t REG_GAIN_D   = 3'd2;
    localparam cfg_idx_t REG_TARGET   = 3'd3;
    localparam cfg_idx_t REG_OFFSET_Y = 3'd4;
    localparam cfg_idx_t REG_OFFSET_Z = 3'd5;
    localparam cfg_idx_t REG_LIMIT    = 3'd6;

endpackage

`default_nettype wire

// ===== rtl/core/tilt_pid_balance_controller_core.sv =====
// Registered stages in order: pre-rotation, CORDIC steps, tilt, error, multiply, output.
// Throughput: one item per cycle while out_stall is low; one vectoring step per stage.
// The PID state update (integral, last error) closes in a single stage.
// Stalls collapse bubbles; input is taken while a result waits until all stages are full.
// Reset (rst_n low, async): pipeline empty, PID state zero, registers at defaults.
`default_nettype none

`include "tilt_pid_balance_controller_core_assert.svh"

// Tilt sensing by pipelined CORDIC feeding a PID law and two servo commands.
module tilt_pid_balance_controller_core
    import tpbc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_y,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_z,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [TILT_W-1:0]           tilt_angle,
    output logic signed [DRIVE_W-1:0]          drive_level,
    output logic [WHEEL_W-1:0]                 left_wheel,
    output logic [WHEEL_W-1:0]                 right_wheel
);

    localparam int CW     = ((SAMPLE_BITS > OFF_W) ? SAMPLE_BITS : OFF_W) + 1;
    localparam int XW     = CW + 1 + FRAC_BITS + 3;
    localparam int ZW     = ANGLE_W;
    localparam int ST_T   = CORDIC_STEPS + 1;
    localparam int ST_E   = CORDIC_STEPS + 2;
    localparam int ST_M   = CORDIC_STEPS + 3;
    localparam int ST_O   = CORDIC_STEPS + 4;
    localparam int NS     = CORDIC_STEPS + 5;
    localparam int SRV_W  = WHEEL_W + 2;

    // Configuration registers
    logic signed [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [TILT_W-1:0] target_reg;
    logic signed [OFF_W-1:0]  off_y_reg, off_z_reg;
    logic [LIM_W-1:0]         limit_reg;

    // Pipeline control
    logic [NS-1:0] vld_reg, vld_next, vld_up;
    logic [NS:0]   rdy;

    // CORDIC stage registers: index 0 is the pre-rotation stage
    logic signed [XW-1:0] xv_reg [CORDIC_STEPS+1];
    logic signed [XW-1:0] yv_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] zv_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] zf_reg;

    // Pre-rotation logic
    logic signed [CW-1:0]           cy_c, cz_c;
    logic signed [CW:0]             ny_c, nz_c;
    logic signed [CW+FRAC_BITS:0]   xs_c, ys_c;
    logic signed [XW-1:0]           x0_c, y0_c, xp_c, yp_c;
    logic signed [ZW-1:0]           zp_c;
    logic                           zero_c;

    // Tilt stage
    logic signed [ZW:0]       zr_c, zq_c;
    logic signed [TILT_W-1:0] tilt_c, tilt_t_reg;

    // Error stage (last_err_reg is both PID state and the stage's error)
    logic signed [ERR_W-1:0]  err_c, last_err_reg;
    logic signed [ACC_W:0]    acc_sum_c, lim_s_c;
    logic signed [ACC_W-1:0]  acc_next, acc_reg;
    logic signed [DER_W-1:0]  der_c, der_reg;
    logic signed [TILT_W-1:0] tilt_e_reg;
    logic                     ld_e;

    // Multiply stage
    logic signed [PP_W-1:0]   pp_c, pp_reg;
    logic signed [PI_W-1:0]   pi_c, pi_reg;
    logic signed [PD_W-1:0]   pd_c, pd_reg;
    logic signed [TILT_W-1:0] tilt_m_reg;

    // Output stage
    logic signed [SUM_W-1:0]   sum_c, quo_c;
    logic signed [DRIVE_W-1:0] drv_c, srv_c;
    logic signed [SRV_W-1:0]   lw_c, rw_c;
    logic signed [TILT_W-1:0]  tilt_o_reg;
    logic signed [DRIVE_W-1:0] drive_o_reg;
    logic [WHEEL_W-1:0]        left_o_reg, right_o_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_W'(GAIN_P_RST);
            gain_i_reg <= GAIN_W'(GAIN_I_RST);
            gain_d_reg <= GAIN_W'(GAIN_D_RST);
            target_reg <= TILT_W'(TARGET_RST);
            off_y_reg  <= OFF_W'(OFF_Y_RST);
            off_z_reg  <= OFF_W'(OFF_Z_RST);
            limit_reg  <= LIM_W'(LIMIT_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:   gain_p_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   gain_i_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   gain_d_reg <= cfg_data[GAIN_W-1:0];
                REG_TARGET:   target_reg <= cfg_data[TILT_W-1:0];
                REG_OFFSET_Y: off_y_reg  <= cfg_data[OFF_W-1:0];
                REG_OFFSET_Z: off_z_reg  <= cfg_data[OFF_W-1:0];
                REG_LIMIT:    limit_reg  <= cfg_data[LIM_W-1:0];
                default:      ;
            endcase
        end
    end

    // Ready chain: a stage takes data when empty or when it drains downstream
    assign rdy[NS] = !out_stall;
    for (genvar k = 0; k < NS; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign vld_up   = {vld_reg[NS-2:0], in_valid};
    assign in_stall = !rdy[0];

    // Advance valid bits
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            vld_next[k] = rdy[k] ? vld_up[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Remove offsets, scale and rotate into the right half plane
    always_comb
    begin
        cy_c   = CW'(accel_y) - CW'(off_y_reg);
        cz_c   = CW'(accel_z) - CW'(off_z_reg);
        ny_c   = -((CW+1)'(cy_c));
        nz_c   = (CW+1)'(cz_c);
        zero_c = (cy_c == '0) && (cz_c == '0);
        xs_c   = {nz_c, {FRAC_BITS{1'b0}}};
        ys_c   = {ny_c, {FRAC_BITS{1'b0}}};
        x0_c   = XW'(xs_c);
        y0_c   = XW'(ys_c);
        xp_c   = x0_c;
        yp_c   = y0_c;
        zp_c   = '0;
        if (x0_c[XW-1])
        begin
            if (!y0_c[XW-1])
            begin
                xp_c = y0_c;
                yp_c = -x0_c;
                zp_c = ZW'(Z_QUARTER);
            end
            else
            begin
                xp_c = -y0_c;
                yp_c = x0_c;
                zp_c = -(ZW'(Z_QUARTER));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            xv_reg[0] <= xp_c;
            yv_reg[0] <= yp_c;
            zv_reg[0] <= zp_c;
            zf_reg[0] <= zero_c;
        end
    end

    // One vectoring step per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [XW-1:0] dx, dy, xn, yn;
        logic signed [ZW-1:0] tab, zn;

        always_comb
        begin
            dx  = yv_reg[i] >>> i;
            dy  = xv_reg[i] >>> i;
            tab = ZW'(ATAN_TAB[i]);
            if (!yv_reg[i][XW-1])
            begin
                xn = xv_reg[i] + dx;
                yn = yv_reg[i] - dy;
                zn = zv_reg[i] + tab;
            end
            else
            begin
                xn = xv_reg[i] - dx;
                yn = yv_reg[i] + dy;
                zn = zv_reg[i] - tab;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i+1])
            begin
                xv_reg[i+1] <= xn;
                yv_reg[i+1] <= yn;
                zv_reg[i+1] <= zn;
                zf_reg[i+1] <= zf_reg[i];
            end
        end
    end

    // Round the angle to 1/256 degree and clamp to a half turn
    always_comb
    begin
        zr_c = (ZW+1)'(zv_reg[CORDIC_STEPS]) + (ZW+1)'(ROUND_HALF);
        zq_c = zr_c >>> ROUND_SHIFT;
        if (zf_reg[CORDIC_STEPS])
        begin
            tilt_c = '0;
        end
        else if (zq_c > (ZW+1)'(ANGLE_MAX))
        begin
            tilt_c = TILT_W'(ANGLE_MAX);
        end
        else if (zq_c < -((ZW+1)'(ANGLE_MAX)))
        begin
            tilt_c = -(TILT_W'(ANGLE_MAX));
        end
        else
        begin
            tilt_c = zq_c[TILT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_T])
        begin
            tilt_t_reg <= tilt_c;
        end
    end

    // Error, clamped integral and derivative
    assign ld_e = rdy[ST_E] && vld_reg[ST_T];

    always_comb
    begin
        err_c     = ERR_W'(tilt_t_reg) - ERR_W'(target_reg);
        acc_sum_c = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(err_c);
        lim_s_c   = $signed({{(ACC_W+1-LIM_W){1'b0}}, limit_reg});
        if (acc_sum_c > lim_s_c)
        begin
            acc_next = lim_s_c[ACC_W-1:0];
        end
        else if (acc_sum_c < -lim_s_c)
        begin
            acc_next = ACC_W'(-lim_s_c);
        end
        else
        begin
            acc_next = acc_sum_c[ACC_W-1:0];
        end
        der_c = DER_W'(err_c) - DER_W'(last_err_reg);
    end

    // Update PID state once per item, as it enters the error stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            last_err_reg <= '0;
        end
        else if (ld_e)
        begin
            acc_reg      <= acc_next;
            last_err_reg <= err_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_e)
        begin
            der_reg    <= der_c;
            tilt_e_reg <= tilt_t_reg;
        end
    end

    // Gain products
    always_comb
    begin
        pp_c = PP_W'(gain_p_reg) * PP_W'(last_err_reg);
        pi_c = PI_W'(gain_i_reg) * PI_W'(acc_reg);
        pd_c = PD_W'(gain_d_reg) * PD_W'(der_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_M])
        begin
            pp_reg     <= pp_c;
            pi_reg     <= pi_c;
            pd_reg     <= pd_c;
            tilt_m_reg <= tilt_e_reg;
        end
    end

    // Sum, truncate toward zero, saturate and derive servo commands
    always_comb
    begin
        sum_c = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);
        quo_c = sum_c >>> DRIVE_SHIFT;
        if (sum_c[SUM_W-1] && (sum_c[DRIVE_SHIFT-1:0] != '0))
        begin
            quo_c = quo_c + SUM_W'(1);
        end
        if (quo_c > SUM_W'(DRIVE_MAX))
        begin
            drv_c = DRIVE_W'(DRIVE_MAX);
        end
        else if (quo_c < -(SUM_W'(DRIVE_MAX)))
        begin
            drv_c = -(DRIVE_W'(DRIVE_MAX));
        end
        else
        begin
            drv_c = quo_c[DRIVE_W-1:0];
        end
        if (drv_c > DRIVE_W'(SERVO_SPAN))
        begin
            srv_c = DRIVE_W'(SERVO_SPAN);
        end
        else if (drv_c < -(DRIVE_W'(SERVO_SPAN)))
        begin
            srv_c = -(DRIVE_W'(SERVO_SPAN));
        end
        else
        begin
            srv_c = drv_c;
        end
        lw_c = SRV_W'(SERVO_SPAN) + SRV_W'(srv_c);
        rw_c = SRV_W'(SERVO_SPAN) - SRV_W'(srv_c);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_O])
        begin
            tilt_o_reg  <= tilt_m_reg;
            drive_o_reg <= drv_c;
            left_o_reg  <= lw_c[WHEEL_W-1:0];
            right_o_reg <= rw_c[WHEEL_W-1:0];
        end
    end

    // Drive result ports
    assign out_valid   = vld_reg[ST_O];
    assign tilt_angle  = tilt_o_reg;
    assign drive_level = drive_o_reg;
    assign left_wheel  = left_o_reg;
    assign right_wheel = right_o_reg;

    // Checks
    `TPBC_ASSERT_IMP(a_wheel_sum, clk, rst_n, out_valid, (9'(left_wheel) + 9'(right_wheel)) == 9'(WHEEL_SUM), "servo commands do not span the full range")
    `TPBC_ASSERT_IMP(a_no_stall_pass, clk, rst_n, !out_stall, !in_stall, "input stalled while output drains")
    `TPBC_ASSERT_NXT(a_acc_in_limit, clk, rst_n, ld_e, (acc_reg <= $signed({2'b00, limit_reg})) && (acc_reg >= -$signed({2'b00, limit_reg})), "integral outside its limit after update")

endmodule

`default_nettype wire
